/* design/vn_pkg.sv */
package vn_pkg;

   // Field widths fixed by the interface
   localparam int IN_W   = 16;
   localparam int OUT_W  = 14;
   localparam int SUM_W  = 32;
   localparam int ROOT_W = SUM_W / 2;

   // Default number of fraction bits
   localparam int FRAC_BITS_DEF = 12;

endpackage

/* design/vector3_normalize.sv */
// Normalizes one signed fixed-point 3-vector per clock. A beat is taken at
// every edge with start high; busy is always low since the pipeline never
// stalls. Each result appears with rsp_strobe high for one cycle, after a
// squaring register, a summing register, 16 square-root stages (one root
// bit each), an entry stage, the divide stages (one quotient bit each) and
// an output register. The receiver cannot hold results off. A zero vector
// returns zero components with rsp_was_zero set.
module vector3_normalize import vn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [IN_W-1:0]  req_in_x,
   input  logic signed [IN_W-1:0]  req_in_y,
   input  logic signed [IN_W-1:0]  req_in_z,
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_out_x,
   output logic signed [OUT_W-1:0] rsp_out_y,
   output logic signed [OUT_W-1:0] rsp_out_z,
   output logic                    rsp_was_zero
);

   localparam int RW      = ROOT_W + 2;
   localparam int DIV_LAT = FRAC_BITS + 3;

   // Front: squares, then sum
   logic                   v_sq_ff, v_sum_ff;
   logic [SUM_W-1:0]       sqx_ff, sqy_ff, sqz_ff, sum_ff;
   logic signed [IN_W-1:0] x0_ff, y0_ff, z0_ff, x1_ff, y1_ff, z1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_sq_ff  <= 1'b0;
         v_sum_ff <= 1'b0;
      end else begin
         v_sq_ff  <= start;
         v_sum_ff <= v_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff <= SUM_W'(req_in_x * req_in_x);
      sqy_ff <= SUM_W'(req_in_y * req_in_y);
      sqz_ff <= SUM_W'(req_in_z * req_in_z);
      x0_ff  <= req_in_x;
      y0_ff  <= req_in_y;
      z0_ff  <= req_in_z;
      sum_ff <= sqx_ff + sqy_ff + sqz_ff;
      x1_ff  <= x0_ff;
      y1_ff  <= y0_ff;
      z1_ff  <= z0_ff;
   end

   // Square root, one root bit per stage
   logic                   sv_ff  [ROOT_W+1];
   logic [SUM_W-1:0]       rad_ff [ROOT_W+1];
   logic [RW-1:0]          srem_ff[ROOT_W+1];
   logic [ROOT_W-1:0]      root_ff[ROOT_W+1];
   logic signed [IN_W-1:0] sx_ff  [ROOT_W+1];
   logic signed [IN_W-1:0] sy_ff  [ROOT_W+1];
   logic signed [IN_W-1:0] sz_ff  [ROOT_W+1];

   assign sv_ff[0]   = v_sum_ff;
   assign rad_ff[0]  = sum_ff;
   assign srem_ff[0] = '0;
   assign root_ff[0] = '0;
   assign sx_ff[0]   = x1_ff;
   assign sy_ff[0]   = y1_ff;
   assign sz_ff[0]   = z1_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      logic [RW+1:0] rs;
      logic [RW+1:0] trial;
      assign rs    = {srem_ff[i], rad_ff[i][SUM_W-1-2*i -: 2]};
      assign trial = {2'b00, root_ff[i], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i+1] <= 1'b0;
         end else begin
            sv_ff[i+1] <= sv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (rs >= trial) begin
            srem_ff[i+1] <= RW'(rs - trial);
            root_ff[i+1] <= {root_ff[i][ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff[i+1] <= RW'(rs);
            root_ff[i+1] <= {root_ff[i][ROOT_W-2:0], 1'b0};
         end
         rad_ff[i+1] <= rad_ff[i];
         sx_ff[i+1]  <= sx_ff[i];
         sy_ff[i+1]  <= sy_ff[i];
         sz_ff[i+1]  <= sz_ff[i];
      end
   end

   // Divide lanes
   logic [OUT_W-1:0] qx, qy, qz;

   vn_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .comp(sx_ff[ROOT_W]), .mag(root_ff[ROOT_W]), .quot(qx));
   vn_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .comp(sy_ff[ROOT_W]), .mag(root_ff[ROOT_W]), .quot(qy));
   vn_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock(clock), .comp(sz_ff[ROOT_W]), .mag(root_ff[ROOT_W]), .quot(qz));

   // Valid and zero flag ride alongside the lanes
   logic dv_ff [DIV_LAT+1];
   logic dz_ff [DIV_LAT+1];

   assign dv_ff[0] = sv_ff[ROOT_W];
   assign dz_ff[0] = (root_ff[ROOT_W] == '0);

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         dz_ff[k+1] <= dz_ff[k];
      end
   end

   // Result beat
   assign busy         = 1'b0;
   assign rsp_strobe   = dv_ff[DIV_LAT];
   assign rsp_was_zero = dz_ff[DIV_LAT];
   assign rsp_out_x    = dz_ff[DIV_LAT] ? '0 : qx;
   assign rsp_out_y    = dz_ff[DIV_LAT] ? '0 : qy;
   assign rsp_out_z    = dz_ff[DIV_LAT] ? '0 : qz;

endmodule

/* design/vn_div.sv */
// One divide lane: clamp(|comp| * 2^FRAC_BITS / mag) with the sign put back.
// One quotient bit per division stage, between an entry stage and an output register.
module vn_div import vn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic signed [IN_W-1:0]   comp,
   input  logic        [ROOT_W-1:0] mag,
   output logic        [OUT_W-1:0]  quot
);

   localparam int DW = IN_W + FRAC_BITS;
   localparam int NS = FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 1;

   logic [DW-1:0]     rem_ff [NS+1];
   logic [QW-1:0]     q_ff   [NS+1];
   logic [ROOT_W-1:0] mag_ff [NS+1];
   logic              neg_ff [NS+1];
   logic              ovf_ff [NS+1];
   logic [OUT_W-1:0]  quot_ff;

   logic [IN_W-1:0]   comp_abs;
   logic [QW-1:0]     q_sat;
   logic [IN_W-1:0]   q_ext;
   logic [IN_W-1:0]   q_signed;

   // Magnitude of the component; the most negative value comes out right as unsigned
   assign comp_abs = comp[IN_W-1] ? IN_W'(-comp) : IN_W'(comp);

   // Entry stage: quotient of 2^(FRAC_BITS+1) or more saturates anyway
   always_ff @(posedge clock) begin
      rem_ff[0] <= {comp_abs, FRAC_BITS'(0)};
      q_ff[0]   <= '0;
      mag_ff[0] <= mag;
      neg_ff[0] <= comp[IN_W-1];
      ovf_ff[0] <= {1'b0, comp_abs} >= {mag, 1'b0};
   end

   // Restoring division, quotient bit FRAC_BITS-j in stage j
   for (genvar j = 0; j < NS; j++) begin : g_bit
      localparam int K = FRAC_BITS - j;
      logic [DW-1:0] trial;
      assign trial = {{(DW-ROOT_W){1'b0}}, mag_ff[j]} << K;
      always_ff @(posedge clock) begin
         if (rem_ff[j] >= trial) begin
            rem_ff[j+1] <= rem_ff[j] - trial;
            q_ff[j+1]   <= q_ff[j] | (QW'(1) << K);
         end else begin
            rem_ff[j+1] <= rem_ff[j];
            q_ff[j+1]   <= q_ff[j];
         end
         mag_ff[j+1] <= mag_ff[j];
         neg_ff[j+1] <= neg_ff[j];
         ovf_ff[j+1] <= ovf_ff[j];
      end
   end

   // Saturate to one, restore sign, truncate to the field
   assign q_sat    = (ovf_ff[NS] || q_ff[NS] > (QW'(1) << FRAC_BITS))
                     ? (QW'(1) << FRAC_BITS) : q_ff[NS];
   assign q_ext    = IN_W'(q_sat);
   assign q_signed = neg_ff[NS] ? -q_ext : q_ext;

   always_ff @(posedge clock) begin
      quot_ff <= q_signed[OUT_W-1:0];
   end

   assign quot = quot_ff;

endmodule

/* verif/tb_vector3_normalize.sv */
module tb_vector3_normalize;
   import vn_pkg::*;

   localparam int FRAC    = FRAC_BITS_DEF;
   localparam int LATENCY = FRAC + 21;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [IN_W-1:0]  req_in_x;
   logic signed [IN_W-1:0]  req_in_y;
   logic signed [IN_W-1:0]  req_in_z;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_out_x;
   logic signed [OUT_W-1:0] rsp_out_y;
   logic signed [OUT_W-1:0] rsp_out_z;
   logic                    rsp_was_zero;

   typedef struct packed {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic [OUT_W-1:0] z;
      logic             zero;
   } unit_vec_type;

   unit_vec_type unit_q[$];
   int        n_errors;
   int        n_beats;
   int        n_zero;
   int        n_sat;

   vector3_normalize #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .rsp_strobe(rsp_strobe), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_was_zero(rsp_was_zero)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Floored integer square root, bit by bit
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Component over magnitude, truncated, saturated to +/- one, wrapped to width
   function automatic logic [OUT_W-1:0] unit_comp(input longint c,
                                                  input longint unsigned mag);
      longint unsigned a;
      longint unsigned q;
      longint          r;
      a = (c < 0) ? -c : c;
      q = (a << FRAC) / mag;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      r = (c < 0) ? -longint'(q) : longint'(q);
      return r[OUT_W-1:0];
   endfunction

   function automatic unit_vec_type unit_vector(input logic signed [IN_W-1:0] x,
                                                input logic signed [IN_W-1:0] y,
                                                input logic signed [IN_W-1:0] z);
      longint          sx, sy, sz;
      longint unsigned mag;
      unit_vec_type    u;
      sx  = x;
      sy  = y;
      sz  = z;
      mag = floor_root(sx * sx + sy * sy + sz * sz);
      if (mag == 0) begin
         u = '0;
         u.zero = 1'b1;
      end else begin
         u.x = unit_comp(sx, mag);
         u.y = unit_comp(sy, mag);
         u.z = unit_comp(sz, mag);
         u.zero = 1'b0;
      end
      return u;
   endfunction

   task automatic report(input string what, input logic [OUT_W-1:0] got,
                         input logic [OUT_W-1:0] want);
      n_errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // Send one beat; optional gap before it
   task automatic send_vec(input logic signed [IN_W-1:0] x,
                           input logic signed [IN_W-1:0] y,
                           input logic signed [IN_W-1:0] z,
                           input int gap);
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      unit_q.push_back(unit_vector(x, y, z));
      n_beats++;
      @(negedge clock);
   endtask

   task automatic idle_line();
      start <= 1'b0;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Result checker
   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_strobe) begin
         if (unit_q.size() == 0) begin
            n_errors++;
            $display("MISMATCH: result with nothing expected at %0t", $time);
         end else begin
            want = unit_q.pop_front();
            if (rsp_out_x !== want.x) report("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report("out_z", rsp_out_z, want.z);
            if (rsp_was_zero !== want.zero)
               report("was_zero", OUT_W'(rsp_was_zero), OUT_W'(want.zero));
            if (want.zero) n_zero++;
            if (want.x == OUT_W'(1 << FRAC) || want.x == OUT_W'(-(1 << FRAC)))
               n_sat++;
         end
      end
   end

   // Extremes, zero vector, axes, tiny and saturating vectors
   task automatic test_directed();
      send_vec(16'sd0, 16'sd0, 16'sd0, 0);
      send_vec(16'sh7fff, 16'sd0, 16'sd0, 0);
      send_vec(-16'sh8000, 16'sd0, 16'sd0, 0);
      send_vec(16'sd0, 16'sh7fff, 16'sd0, 1);
      send_vec(16'sd0, -16'sh8000, 16'sd0, 0);
      send_vec(16'sd0, 16'sd0, 16'sh7fff, 0);
      send_vec(16'sd0, 16'sd0, -16'sh8000, 2);
      send_vec(-16'sh8000, -16'sh8000, -16'sh8000, 0);
      send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_vec(16'sh7fff, -16'sh8000, 16'sh7fff, 0);
      send_vec(16'sd1, 16'sd0, 16'sd0, 0);
      send_vec(-16'sd1, 16'sd0, 16'sd0, 0);
      send_vec(16'sd1, 16'sd1, 16'sd0, 0);
      send_vec(16'sd1, -16'sd1, 16'sd1, 0);
      send_vec(16'sd3, 16'sd4, 16'sd0, 0);
      send_vec(16'sd4096, 16'sd0, 16'sd0, 0);
      send_vec(16'sd4096, 16'sd4096, 16'sd4096, 0);
      send_vec(-16'sd2, 16'sd3, -16'sd1, 0);
      send_vec(16'sh5555, -16'sh2aab, 16'sh0f0f, 0);
      send_vec(16'sd0, 16'sd0, 16'sd0, 5);
   endtask

   // Random vectors: full range, small, and single-axis mixes
   task automatic test_random(input int count);
      logic signed [IN_W-1:0] v[3];
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         for (int k = 0; k < 3; k++) begin
            if (mode < 5) v[k] = IN_W'($urandom);
            else if (mode < 8) v[k] = $signed(IN_W'($urandom_range(0, 15))) - 16'sd8;
            else v[k] = ($urandom_range(0, 2) == k) ? IN_W'($urandom) : '0;
         end
         send_vec(v[0], v[1], v[2], (i % 400 < 100) ? 0 : pick_gap());
      end
   endtask

   initial begin
      int waited;
      n_errors = 0;
      n_beats  = 0;
      n_zero   = 0;
      n_sat    = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(2000);
      idle_line();

      // drain
      waited = 0;
      while (unit_q.size() != 0 && waited < 10 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (unit_q.size() != 0) begin
         n_errors++;
         $display("MISMATCH: %0d results never arrived", unit_q.size());
      end

      $display("Sent %0d vectors: %0d zero, %0d with saturated x.",
               n_beats, n_zero, n_sat);
      if (n_errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
